// ----- hdl/ddpid_pkg.sv -----
// Types, constants and helper functions shared by the two-wheel speed PID blocks.
// No dependencies.
package ddpid_pkg;

  localparam int ALPHA_ONE    = 4096;
  localparam int FRAC_SHIFT   = 12;
  localparam int HT_FRAC      = 16;
  localparam int CMD_FRAC     = 18;
  localparam int DUTY_PCT_MAX = 100;
  localparam int DUTY_SCALE   = 30;

  localparam int SPD_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int ALPHA_W = 13;
  localparam int LIM_W   = 31;
  localparam int DL_W    = 7;
  localparam int DUTY_W  = 12;
  localparam int DV_W    = 17;
  localparam int ERR_W   = 20;
  localparam int INT_W   = 32;
  localparam int CFG_IDX_W = 3;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int MAG_W   = DL_W + CMD_FRAC;
  localparam int SCL_W   = MAG_W + 5;

  localparam logic signed [ACC_W-1:0] ERR_HI = ACC_W'(2 ** (ERR_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] ERR_LO = ACC_W'(-(2 ** (ERR_W - 1)));

  typedef struct packed {
    logic signed [SPD_W-1:0] measured_speed;
    logic signed [SPD_W-1:0] measured_turn;
    logic signed [SPD_W-1:0] target_speed;
    logic signed [SPD_W-1:0] target_turn;
  } in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] left_duty;
    logic              left_reverse;
    logic [DUTY_W-1:0] right_duty;
    logic              right_reverse;
  } out_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              rev;
  } wheel_out_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_SMOOTHING,
    REG_HALF_TRACK,
    REG_INT_LIMIT,
    REG_DUTY_LIMIT
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_DV,
    S_MUL_CDV,
    S_ERR,
    S_E_MIX,
    S_E_DONE,
    S_D_MIX,
    S_D_DONE,
    S_CMD_I,
    S_CMD_D,
    S_CMD_SUM,
    S_FIN
  } state_t;

  typedef struct packed {
    state_t st;
    logic   wheel;
  } ctrl_t;

  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [ACC_W-1:0] sum);
    logic signed [ACC_W-1:0] sh;
    logic signed [ERR_W-1:0] r;
    sh = sum >>> FRAC_SHIFT;
    if (sh > ERR_HI) begin
      r = ERR_HI[ERR_W-1:0];
    end else if (sh < ERR_LO) begin
      r = ERR_LO[ERR_W-1:0];
    end else begin
      r = sh[ERR_W-1:0];
    end
    return r;
  endfunction

  function automatic wheel_out_t finalize(input logic signed [ACC_W-1:0] cmd,
                                          input logic [DL_W-1:0] dl);
    logic [ACC_W-1:0] mag;
    logic [DL_W-1:0]  dl_eff;
    logic [MAG_W-1:0] lim;
    logic [MAG_W-1:0] m;
    logic [SCL_W-1:0] scaled;
    wheel_out_t       r;
    mag    = cmd[ACC_W-1] ? $unsigned(-cmd) : $unsigned(cmd);
    dl_eff = (dl > DL_W'(DUTY_PCT_MAX)) ? DL_W'(DUTY_PCT_MAX) : dl;
    lim    = MAG_W'(dl_eff) << CMD_FRAC;
    m      = (mag > {{(ACC_W - MAG_W){1'b0}}, lim}) ? lim : mag[MAG_W-1:0];
    scaled = (SCL_W'(m) << 5) - (SCL_W'(m) << 1);
    r.duty = scaled[CMD_FRAC +: DUTY_W];
    r.rev  = cmd[ACC_W-1];
    return r;
  endfunction

endpackage

// ----- hdl/ddpid_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on ddpid_pkg for operand and product widths.
module ddpid_mul import ddpid_pkg::*; (
  input  logic                       clk,
  input  logic signed [MUL_A_W-1:0]  a,
  input  logic signed [MUL_B_W-1:0]  b,
  output logic signed [PROD_W-1:0]   prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ----- hdl/ddpid_seq.sv -----
// Sequencer that steps the shared multiplier through both wheels of one tick.
// Depends on ddpid_pkg for the state and control types.
module ddpid_seq import ddpid_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  out_free,
  output ctrl_t ctrl
);

  state_t state, state_next;
  logic   wheel, wheel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wheel <= 1'b0;
    end else begin
      state <= state_next;
      wheel <= wheel_next;
    end
  end

  always_comb begin
    state_next = state;
    wheel_next = wheel;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_MUL_DV;
        end
      end
      S_MUL_DV:  state_next = S_MUL_CDV;
      S_MUL_CDV: state_next = S_ERR;
      S_ERR: begin
        state_next = S_E_MIX;
        wheel_next = 1'b0;
      end
      S_E_MIX:  state_next = S_E_DONE;
      S_E_DONE: state_next = S_D_MIX;
      S_D_MIX:  state_next = S_D_DONE;
      S_D_DONE: state_next = S_CMD_I;
      S_CMD_I:  state_next = S_CMD_D;
      S_CMD_D:  state_next = S_CMD_SUM;
      S_CMD_SUM: begin
        if (!wheel) begin
          state_next = S_E_MIX;
          wheel_next = 1'b1;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign ctrl = '{st: state, wheel: wheel};

endmodule

// ----- hdl/diff_drive_speed_pid_pwm.sv -----
// Top level of the two-wheel speed PID with duty output.
// Depends on ddpid_pkg, ddpid_mul and ddpid_seq.
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries one control tick
//   (measured and target speed and turn rate). Output channel out_valid /
//   out_stall / out_data carries the left and right duty counts and
//   direction bits. A transfer happens when valid is high and stall is low.
//   The cfg channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes one
//   register per transfer; write only while no tick is in flight.
//   Ticks are taken one at a time: in_stall is high from the input transfer
//   until the result is loaded, and the next tick is taken in the idle state.
//   The single 33x17 multiplier is reused for every product of a tick; its
//   product is registered, and the result is loaded into an output register.
//   A stalled output holds its value; a finished tick waits in the last step
//   until the output register is free, then the next tick is taken while the
//   earlier result still waits for its transfer.
//   Reset restores the register defaults and clears the stored error, derivative and integral state of both wheels.
module diff_drive_speed_pid_pwm import ddpid_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIM_W-1:0]     cfg_data
);

  logic [GAIN_W-1:0]  gain_p, gain_i, gain_d, half_track;
  logic [ALPHA_W-1:0] smoothing;
  logic [LIM_W-1:0]   integral_limit;
  logic [DL_W-1:0]    duty_limit;

  ctrl_t ctrl;
  logic  start;
  logic  out_free;

  in_t in_q;
  logic signed [DV_W-1:0]  dv;
  logic signed [ERR_W-1:0] err_q [2];
  logic signed [ERR_W-1:0] e_st [2];
  logic signed [ERR_W-1:0] d_st [2];
  logic signed [INT_W-1:0] i_st [2];
  logic signed [ERR_W-1:0] e_new, d_new;
  logic signed [INT_W-1:0] i_new;
  logic signed [ACC_W-1:0] acc, cmd;
  wheel_out_t              left_res;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic [ALPHA_W-1:0]       alpha, one_minus;
  logic signed [ACC_W-1:0]  acc_sum;
  logic signed [ERR_W-1:0]  ts_x, ms_x, dv_x, cdv_x, err_l_next, err_r_next;
  logic signed [ERR_W:0]    e_diff;
  logic signed [INT_W:0]    i_sum, i_lim;
  logic signed [INT_W-1:0]  i_next;

  assign start     = in_valid && !in_stall;
  assign in_stall  = (ctrl.st != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  ddpid_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  ddpid_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= GAIN_W'(6400);
      gain_i         <= GAIN_W'(64);
      gain_d         <= GAIN_W'(32000);
      smoothing      <= ALPHA_W'(1229);
      half_track     <= GAIN_W'(9830);
      integral_limit <= LIM_W'(409600);
      duty_limit     <= DL_W'(DUTY_PCT_MAX);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_GAIN_P:     gain_p         <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:     gain_i         <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:     gain_d         <= cfg_data[GAIN_W-1:0];
        REG_SMOOTHING:  smoothing      <= cfg_data[ALPHA_W-1:0];
        REG_HALF_TRACK: half_track     <= cfg_data[GAIN_W-1:0];
        REG_INT_LIMIT:  integral_limit <= cfg_data;
        REG_DUTY_LIMIT: duty_limit     <= cfg_data[DL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    alpha      = (smoothing > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : smoothing;
    one_minus  = ALPHA_W'(ALPHA_ONE) - alpha;
    acc_sum    = acc + ACC_W'(prod);
    ts_x       = ERR_W'(in_q.target_speed);
    ms_x       = ERR_W'(in_q.measured_speed);
    dv_x       = ERR_W'(dv);
    cdv_x      = ERR_W'($signed(prod[HT_FRAC +: DV_W]));
    err_l_next = (ts_x - cdv_x) - (ms_x - dv_x);
    err_r_next = (ts_x + cdv_x) - (ms_x + dv_x);
    e_diff     = (ERR_W + 1)'(e_new) - (ERR_W + 1)'(e_st[ctrl.wheel]);
    i_sum      = (INT_W + 1)'(i_st[ctrl.wheel]) + (INT_W + 1)'(e_new);
    i_lim      = $signed({2'b00, integral_limit});
    if (i_sum > i_lim) begin
      i_next = i_lim[INT_W-1:0];
    end else if (i_sum < -i_lim) begin
      i_next = INT_W'(-i_lim);
    end else begin
      i_next = i_sum[INT_W-1:0];
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.st)
      S_MUL_DV: begin
        mul_a = MUL_A_W'(in_q.measured_turn);
        mul_b = $signed({1'b0, half_track});
      end
      S_MUL_CDV: begin
        mul_a = MUL_A_W'(in_q.target_turn);
        mul_b = $signed({1'b0, half_track});
      end
      S_ERR: begin
        mul_a = MUL_A_W'(e_st[0]);
        mul_b = $signed(MUL_B_W'(one_minus));
      end
      S_E_MIX: begin
        mul_a = MUL_A_W'(err_q[ctrl.wheel]);
        mul_b = $signed(MUL_B_W'(alpha));
      end
      S_E_DONE: begin
        mul_a = MUL_A_W'(d_st[ctrl.wheel]);
        mul_b = $signed(MUL_B_W'(one_minus));
      end
      S_D_MIX: begin
        mul_a = MUL_A_W'(e_diff);
        mul_b = $signed(MUL_B_W'(alpha));
      end
      S_D_DONE: begin
        mul_a = MUL_A_W'(e_new);
        mul_b = $signed({1'b0, gain_p});
      end
      S_CMD_I: begin
        mul_a = MUL_A_W'(i_new);
        mul_b = $signed({1'b0, gain_i});
      end
      S_CMD_D: begin
        mul_a = MUL_A_W'(d_new);
        mul_b = $signed({1'b0, gain_d});
      end
      S_CMD_SUM: begin
        mul_a = MUL_A_W'(e_st[1]);
        mul_b = $signed(MUL_B_W'(one_minus));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      in_q <= in_data;
    end
    case (ctrl.st)
      S_MUL_CDV: dv <= prod[HT_FRAC +: DV_W];
      S_ERR: begin
        err_q[0] <= err_l_next;
        err_q[1] <= err_r_next;
      end
      S_E_MIX: begin
        acc <= ACC_W'(prod);
        if (ctrl.wheel) begin
          left_res <= finalize(cmd, duty_limit);
        end
      end
      S_E_DONE: e_new <= sat_err(acc_sum);
      S_D_MIX: begin
        acc   <= ACC_W'(prod);
        i_new <= i_next;
      end
      S_D_DONE:  d_new <= sat_err(acc_sum);
      S_CMD_I:   acc   <= ACC_W'(prod);
      S_CMD_D:   acc   <= acc_sum;
      S_CMD_SUM: cmd   <= acc_sum;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 2; k++) begin
        e_st[k] <= '0;
        d_st[k] <= '0;
        i_st[k] <= '0;
      end
    end else if (ctrl.st == S_CMD_SUM) begin
      e_st[ctrl.wheel] <= e_new;
      d_st[ctrl.wheel] <= d_new;
      i_st[ctrl.wheel] <= i_new;
    end
  end

  wheel_out_t right_res;
  assign right_res = finalize(cmd, duty_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.st == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.st == S_FIN && out_free) begin
      out_data.left_duty     <= left_res.duty;
      out_data.left_reverse  <= left_res.rev;
      out_data.right_duty    <= right_res.duty;
      out_data.right_reverse <= right_res.rev;
    end
  end

  a_load_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(ctrl.st == S_FIN))
    else $error("result appeared without a finished tick");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.left_duty <= DUTY_W'(3000) && out_data.right_duty <= DUTY_W'(3000)))
    else $error("duty count beyond full scale");

  a_start_seq: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (ctrl.st == S_MUL_DV))
    else $error("sequencer did not start on input transfer");

endmodule
